### rtl/assert_macros.svh
// Assertion macros for the RTL, used by d2q9_bgk_collision_top.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check prop at each rising edge, ignored while reset is low.
`define D2Q9_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("d2q9 check failed");
// Check prop at each rising edge, including reset cycles.
`define D2Q9_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("d2q9 check failed");
`else
`define D2Q9_ASSERT(lbl, clk, rstn, prop)
`define D2Q9_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/d2q9_pkg.sv
// Shared types, constants and helpers of the D2Q9 BGK collision pipeline.
// No dependencies.
package d2q9_pkg;

  localparam int NDIR     = 9;
  localparam int OMEGA_W  = 30;
  localparam int QBITS    = 33;
  localparam int DIV_LAT  = QBITS + 2;

  localparam logic [OMEGA_W-1:0] RELAX_RST = 30'd268435456;

  typedef logic [NDIR-1:0][31:0] pops_t;

  typedef struct packed {
    logic [31:0] f_0;
    logic [31:0] f_1;
    logic [31:0] f_2;
    logic [31:0] f_3;
    logic [31:0] f_4;
    logic [31:0] f_5;
    logic [31:0] f_6;
    logic [31:0] f_7;
    logic [31:0] f_8;
  } d2q9_in_t;

  typedef struct packed {
    logic [31:0] out_0;
    logic [31:0] out_1;
    logic [31:0] out_2;
    logic [31:0] out_3;
    logic [31:0] out_4;
    logic [31:0] out_5;
    logic [31:0] out_6;
    logic [31:0] out_7;
    logic [31:0] out_8;
    logic [31:0] density;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
  } d2q9_out_t;

  // Lattice velocities, order rest, E, N, W, S, NE, NW, SW, SE.
  localparam int CX [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int CY [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

  // Weight classes: rest, axis, diagonal.
  localparam int NCLS = 3;
  localparam logic [26:0] WCLS [NCLS] = '{27'd119304647, 27'd29826162, 27'd7456540};
  localparam int DIR_CLS [NDIR] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] SAT_MIN = 64'shffff_ffff_8000_0000;
  localparam logic signed [40:0] Q_ONE   = 41'sd268435456;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'h7fff_ffff;
    end else if (v < SAT_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // c . u for one direction, saturated to 32 bits.
  function automatic logic [31:0] eu_calc(input int cx, input int cy,
                                          input logic [31:0] vx, input logic [31:0] vy);
    logic signed [33:0] tx;
    logic signed [33:0] ty;
    tx = '0;
    ty = '0;
    if (cx == 1) tx = 34'($signed(vx));
    else if (cx == -1) tx = -34'($signed(vx));
    if (cy == 1) ty = 34'($signed(vy));
    else if (cy == -1) ty = -34'($signed(vy));
    return sat32(64'(tx + ty));
  endfunction

endpackage

### rtl/d2q9_div.sv
// Pipelined restoring divider: trunc(num * 2^28 / den), saturated to 32 bits,
// zero when den is not positive. One quotient bit per stage. Uses d2q9_pkg.
module d2q9_div (
  input  logic        clk,
  input  logic        en,
  input  logic [34:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);
  import d2q9_pkg::*;

  logic [30:0]      rem_r  [QBITS+1];
  logic [QBITS-1:0] q_r    [QBITS+1];
  logic [30:0]      den_r  [QBITS+1];
  logic [4:0]       low_r  [QBITS+1];
  logic             neg_r  [QBITS+1];
  logic             ovf_r  [QBITS+1];
  logic             zero_r [QBITS+1];
  logic [31:0]      quo_r;
  logic [31:0]      quo_nxt;

  logic [34:0] mag;
  logic        den_pos;

  assign mag     = num[34] ? (35'd0 - num) : num;
  assign den_pos = !den[31] && (den != 32'd0);

  // Numerator is mag << 28; its part above bit 32 is checked against den first.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {1'b0, mag[34:5]};
      q_r[0]    <= '0;
      den_r[0]  <= den[30:0];
      low_r[0]  <= mag[4:0];
      neg_r[0]  <= num[34];
      ovf_r[0]  <= ({1'b0, mag[34:5]} >= den[30:0]);
      zero_r[0] <= !den_pos;
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_bit
    localparam int J = QBITS - k;
    logic        nb;
    logic [31:0] t;
    logic        ge;
    if (J >= 28) begin : g_num
      assign nb = low_r[k-1][J-28];
    end else begin : g_pad
      assign nb = 1'b0;
    end
    assign t  = {rem_r[k-1], nb};
    assign ge = (t >= {1'b0, den_r[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 31'(t - {1'b0, den_r[k-1]}) : t[30:0];
        q_r[k]    <= {q_r[k-1][QBITS-2:0], ge};
        den_r[k]  <= den_r[k-1];
        low_r[k]  <= low_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
    end
  end

  always_comb begin
    logic [QBITS-1:0] q;
    logic             sat;
    q = q_r[QBITS];
    if (neg_r[QBITS]) begin
      sat = ovf_r[QBITS] || q[32] || (q[31] && (q[30:0] != '0));
    end else begin
      sat = ovf_r[QBITS] || q[32] || q[31];
    end
    if (zero_r[QBITS]) begin
      quo_nxt = '0;
    end else if (neg_r[QBITS]) begin
      quo_nxt = sat ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end else begin
      quo_nxt = sat ? 32'h7fff_ffff : q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

### rtl/d2q9_bgk_collision_top.sv
// D2Q9 BGK collision pipeline, top level. Uses d2q9_pkg, d2q9_div and
// assert_macros.svh.
//
//   port group     | dir | handshake              | payload
//   in_*           | in  | in_valid / in_ready    | d2q9_in_t  (f_0 .. f_8)
//   out_*          | out | out_valid / out_ready  | d2q9_out_t (out_0 .. vel_y)
//   cfg_*          | in  | cfg_we                 | relax_rate, 30 bits
//
// One node per cycle while the output is not stalled. The path runs through
// the moment stages, the 35-stage velocity divider (input register, one
// quotient bit per stage for 33 stages, output register), then the
// equilibrium and relaxation stages. Reset (rst_n low, synchronous) empties
// the pipeline and sets relax_rate to 1.0. While out_valid is high and
// out_ready low the whole pipeline holds and in_ready is low.
`include "assert_macros.svh"

module d2q9_bgk_collision_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  d2q9_pkg::d2q9_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output d2q9_pkg::d2q9_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [d2q9_pkg::OMEGA_W-1:0]     cfg_data
);
  import d2q9_pkg::*;

  logic [OMEGA_W-1:0] relax_r;
  logic               adv;

  // valid bits
  logic v1_r, v2_r, va_r, vb_r, vc_r, vd_r, ve_r, vf_r, out_valid_r;
  logic [DIV_LAT-1:0] dl_v_r;

  // stage 1: moments
  pops_t              in_pops;
  pops_t              f1_r;
  logic signed [35:0] s1_r,  s1_nxt;
  logic signed [34:0] mx1_r, mx1_nxt;
  logic signed [34:0] my1_r, my1_nxt;

  // stage 2: density
  pops_t              f2_r;
  logic [31:0]        d2_r;
  logic [34:0]        mx2_r, my2_r;

  // side line beside the divider
  pops_t              dl_f_r [DIV_LAT];
  logic [31:0]        dl_d_r [DIV_LAT];
  logic [31:0]        vx_div, vy_div;

  // stage A: squares, c.u, weighted density
  pops_t              fa_r;
  logic [31:0]        da_r, vxa_r, vya_r;
  logic signed [63:0] vxx_a_r, vyy_a_r;
  logic [31:0]        eu_a_r  [NDIR];
  logic [31:0]        eu_a_nxt[NDIR];
  logic [31:0]        rw_a_r  [NCLS];
  logic [31:0]        rw_a_nxt[NCLS];
  logic signed [63:0] eusq_a  [NDIR];

  // stage B
  pops_t              fb_r;
  logic [31:0]        db_r, vxb_r, vyb_r;
  logic [31:0]        eu_b_r [NDIR];
  logic [31:0]        rw_b_r [NCLS];
  logic [34:0]        q_b_r  [NDIR];
  logic [35:0]        u2_b_r;

  // stage C
  pops_t              fc_r;
  logic [31:0]        dc_r, vxc_r, vyc_r;
  logic [31:0]        rw_c_r [NCLS];
  logic [31:0]        p_c_r  [NDIR];
  logic [31:0]        p_c_nxt[NDIR];

  // stage D
  pops_t              fd_r;
  logic [31:0]        dd_r, vxd_r, vyd_r;
  logic signed [63:0] pr_d_r [NDIR];

  // stage E
  pops_t              fe_r;
  logic [31:0]        de_r, vxe_r, vye_r;
  logic signed [32:0] df_e_r [NDIR];
  logic signed [32:0] df_e_nxt[NDIR];

  // stage F
  pops_t              ff_r;
  logic [31:0]        df_r, vxf_r, vyf_r;
  logic signed [63:0] mp_f_r [NDIR];

  // output
  d2q9_out_t          out_data_r, out_data_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_pops[0] = in_data.f_0;
  assign in_pops[1] = in_data.f_1;
  assign in_pops[2] = in_data.f_2;
  assign in_pops[3] = in_data.f_3;
  assign in_pops[4] = in_data.f_4;
  assign in_pops[5] = in_data.f_5;
  assign in_pops[6] = in_data.f_6;
  assign in_pops[7] = in_data.f_7;
  assign in_pops[8] = in_data.f_8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relax_r <= RELAX_RST;
    end else if (cfg_we) begin
      relax_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      dl_v_r      <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      ve_r        <= 1'b0;
      vf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      dl_v_r      <= {dl_v_r[DIV_LAT-2:0], v2_r};
      va_r        <= dl_v_r[DIV_LAT-1];
      vb_r        <= va_r;
      vc_r        <= vb_r;
      vd_r        <= vc_r;
      ve_r        <= vd_r;
      vf_r        <= ve_r;
      out_valid_r <= vf_r;
    end
  end

  // Stage 1: exact sum and first moments.
  always_comb begin
    s1_nxt  = '0;
    mx1_nxt = '0;
    my1_nxt = '0;
    for (int i = 0; i < NDIR; i++) begin
      s1_nxt = s1_nxt + 36'($signed(in_pops[i]));
      if (CX[i] == 1) mx1_nxt = mx1_nxt + 35'($signed(in_pops[i]));
      else if (CX[i] == -1) mx1_nxt = mx1_nxt - 35'($signed(in_pops[i]));
      if (CY[i] == 1) my1_nxt = my1_nxt + 35'($signed(in_pops[i]));
      else if (CY[i] == -1) my1_nxt = my1_nxt - 35'($signed(in_pops[i]));
    end
  end

  d2q9_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num (mx2_r),
    .den (d2_r),
    .quo (vx_div)
  );

  d2q9_div u_div_y (
    .clk (clk),
    .en  (adv),
    .num (my2_r),
    .den (d2_r),
    .quo (vy_div)
  );

  // Stage A: c.u per direction and density times weight.
  always_comb begin
    logic signed [59:0] wp;
    for (int i = 0; i < NDIR; i++) begin
      eu_a_nxt[i] = eu_calc(CX[i], CY[i], vx_div, vy_div);
    end
    for (int c = 0; c < NCLS; c++) begin
      wp          = 60'($signed(dl_d_r[DIV_LAT-1]) * $signed({1'b0, WCLS[c]}));
      rw_a_nxt[c] = wp[59:28];
    end
  end

  // Stage B: full-width square of c.u.
  always_comb begin
    for (int i = 0; i < NDIR; i++) begin
      eusq_a[i] = $signed(eu_a_r[i]) * $signed(eu_a_r[i]);
    end
  end

  // Stage C: second-order polynomial per direction.
  always_comb begin
    logic [37:0]        nine_q;
    logic [37:0]        three_u2;
    logic signed [40:0] e41;
    logic [40:0]        p41;
    three_u2 = {1'b0, u2_b_r, 1'b0} + {2'b0, u2_b_r};
    for (int i = 0; i < NDIR; i++) begin
      nine_q     = {q_b_r[i], 3'b0} + {3'b0, q_b_r[i]};
      e41        = 41'($signed(eu_b_r[i]));
      p41        = Q_ONE + e41 + e41 + e41 + 41'(nine_q >> 1) - 41'(three_u2 >> 1);
      p_c_nxt[i] = sat32(64'($signed(p41)));
    end
  end

  // Stage E: saturated equilibrium minus population.
  always_comb begin
    logic [31:0] feq;
    for (int i = 0; i < NDIR; i++) begin
      feq         = sat32(pr_d_r[i] >>> 28);
      df_e_nxt[i] = 33'($signed(feq)) - 33'($signed(fd_r[i]));
    end
  end

  // Output: relax toward the equilibrium.
  always_comb begin
    pops_t r;
    for (int i = 0; i < NDIR; i++) begin
      r[i] = sat32(64'($signed(ff_r[i])) + (mp_f_r[i] >>> 28));
    end
    out_data_nxt.out_0   = r[0];
    out_data_nxt.out_1   = r[1];
    out_data_nxt.out_2   = r[2];
    out_data_nxt.out_3   = r[3];
    out_data_nxt.out_4   = r[4];
    out_data_nxt.out_5   = r[5];
    out_data_nxt.out_6   = r[6];
    out_data_nxt.out_7   = r[7];
    out_data_nxt.out_8   = r[8];
    out_data_nxt.density = df_r;
    out_data_nxt.vel_x   = vxf_r;
    out_data_nxt.vel_y   = vyf_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r  <= in_pops;
      s1_r  <= s1_nxt;
      mx1_r <= mx1_nxt;
      my1_r <= my1_nxt;

      f2_r  <= f1_r;
      d2_r  <= sat32(64'(s1_r));
      mx2_r <= mx1_r;
      my2_r <= my1_r;

      dl_f_r[0] <= f2_r;
      dl_d_r[0] <= d2_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dl_f_r[k] <= dl_f_r[k-1];
        dl_d_r[k] <= dl_d_r[k-1];
      end

      fa_r    <= dl_f_r[DIV_LAT-1];
      da_r    <= dl_d_r[DIV_LAT-1];
      vxa_r   <= vx_div;
      vya_r   <= vy_div;
      vxx_a_r <= $signed(vx_div) * $signed(vx_div);
      vyy_a_r <= $signed(vy_div) * $signed(vy_div);
      eu_a_r  <= eu_a_nxt;
      rw_a_r  <= rw_a_nxt;

      fb_r   <= fa_r;
      db_r   <= da_r;
      vxb_r  <= vxa_r;
      vyb_r  <= vya_r;
      eu_b_r <= eu_a_r;
      rw_b_r <= rw_a_r;
      u2_b_r <= {1'b0, vxx_a_r[62:28]} + {1'b0, vyy_a_r[62:28]};
      for (int i = 0; i < NDIR; i++) begin
        q_b_r[i] <= eusq_a[i][62:28];
      end

      fc_r   <= fb_r;
      dc_r   <= db_r;
      vxc_r  <= vxb_r;
      vyc_r  <= vyb_r;
      rw_c_r <= rw_b_r;
      p_c_r  <= p_c_nxt;

      fd_r  <= fc_r;
      dd_r  <= dc_r;
      vxd_r <= vxc_r;
      vyd_r <= vyc_r;
      for (int i = 0; i < NDIR; i++) begin
        pr_d_r[i] <= $signed(rw_c_r[DIR_CLS[i]]) * $signed(p_c_r[i]);
      end

      fe_r   <= fd_r;
      de_r   <= dd_r;
      vxe_r  <= vxd_r;
      vye_r  <= vyd_r;
      df_e_r <= df_e_nxt;

      ff_r  <= fe_r;
      df_r  <= de_r;
      vxf_r <= vxe_r;
      vyf_r <= vye_r;
      for (int i = 0; i < NDIR; i++) begin
        mp_f_r[i] <= 64'($signed({1'b0, relax_r}) * df_e_r[i]);
      end

      out_data_r <= out_data_nxt;
    end
  end

  `D2Q9_ASSERT(a_vel_zero_no_density, clk, rst_n,
    out_valid && $signed(out_data.density) <= 0 |-> out_data.vel_x == 0 && out_data.vel_y == 0)
  `D2Q9_ASSERT(a_sq_zero_no_density, clk, rst_n,
    vb_r && $signed(db_r) <= 0 |-> u2_b_r == 0)
  `D2Q9_ASSERT_ALWAYS(a_empty_after_reset, clk,
    rst_n && $past(!rst_n) |-> !out_valid && !v1_r)

endmodule

### tb/sv/d2q9_collision_checker.sv
`timescale 1ns / 100ps
// Checker for the D2Q9 BGK collision block: watches both channels, predicts
// each node's result in fixed point and compares it field by field. Uses d2q9_pkg.
module d2q9_collision_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  d2q9_pkg::d2q9_in_t                in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  d2q9_pkg::d2q9_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [d2q9_pkg::OMEGA_W-1:0]      cfg_data,
  output int                                fail_count,
  output int                                pending,
  output int                                nodes_seen
);
  import d2q9_pkg::*;

  localparam int DX [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DY [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam longint WQ [NDIR] = '{119304647, 29826162, 29826162, 29826162, 29826162,
                                    7456540, 7456540, 7456540, 7456540};

  logic [OMEGA_W-1:0] omega_q;
  d2q9_out_t          node_queue[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor division by 2^28
  function automatic longint shr28(longint v);
    return v >>> 28;
  endfunction

  function automatic d2q9_out_t collide_node(d2q9_in_t x, logic [OMEGA_W-1:0] om);
    logic [NDIR-1:0][31:0] fv;
    longint f[NDIR];
    longint s, mx, my, d, vx, vy, u2, eu, q, p, rw, feq, r;
    d2q9_out_t o;
    fv = x;
    s = 0;
    mx = 0;
    my = 0;
    for (int i = 0; i < NDIR; i++) begin
      f[i] = longint'($signed(fv[NDIR-1-i]));
      s += f[i];
      mx += DX[i] * f[i];
      my += DY[i] * f[i];
    end
    d = clamp32(s);
    vx = 0;
    vy = 0;
    if (d > 0) begin
      vx = clamp32((mx * 64'sd268435456) / d);
      vy = clamp32((my * 64'sd268435456) / d);
    end
    u2 = shr28(vx * vx) + shr28(vy * vy);
    for (int i = 0; i < NDIR; i++) begin
      eu = clamp32(DX[i] * vx + DY[i] * vy);
      q = shr28(eu * eu);
      p = clamp32(64'sd268435456 + 3 * eu + ((9 * q) >>> 1) - ((3 * u2) >>> 1));
      rw = shr28(d * WQ[i]);
      feq = clamp32(shr28(rw * p));
      r = clamp32(f[i] + shr28(longint'(om) * (feq - f[i])));
      case (i)
        0: o.out_0 = r[31:0];
        1: o.out_1 = r[31:0];
        2: o.out_2 = r[31:0];
        3: o.out_3 = r[31:0];
        4: o.out_4 = r[31:0];
        5: o.out_5 = r[31:0];
        6: o.out_6 = r[31:0];
        7: o.out_7 = r[31:0];
        default: o.out_8 = r[31:0];
      endcase
    end
    o.density = d[31:0];
    o.vel_x = vx[31:0];
    o.vel_y = vy[31:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t node %0d %s: got %h, want %h", $time, nodes_seen, what, got, want);
    fail_count++;
  endtask

  task automatic compare_node(d2q9_out_t got, d2q9_out_t want);
    logic [11:0][31:0] g;
    logic [11:0][31:0] w;
    string names [12] = '{"out_0", "out_1", "out_2", "out_3", "out_4", "out_5", "out_6",
                          "out_7", "out_8", "density", "vel_x", "vel_y"};
    g = got;
    w = want;
    for (int k = 0; k < 12; k++)
      if (g[11-k] !== w[11-k]) report_mismatch(names[k], g[11-k], w[11-k]);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    nodes_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      omega_q <= RELAX_RST;
    end else begin
      if (cfg_we) omega_q <= cfg_data;
      if (in_valid && in_ready) node_queue.push_back(collide_node(in_data, omega_q));
      if (out_valid && out_ready) begin
        if (node_queue.size() == 0) begin
          $display("%0t result with no node pending", $time);
          fail_count++;
        end else begin
          compare_node(out_data, node_queue.pop_front());
        end
        nodes_seen++;
      end
      pending = node_queue.size();
    end
  end
endmodule

### tb/sv/d2q9_bgk_collision_top_tb.sv
`timescale 1ns / 100ps
// Top of the D2Q9 BGK collision testbench: clock, reset, node stimulus,
// relax-rate phases and verdict. Uses d2q9_pkg and d2q9_collision_checker.
module d2q9_bgk_collision_top_tb;
  import d2q9_pkg::*;

  localparam int LATENCY    = 44;
  localparam int IDLE_LIMIT = 20000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  d2q9_in_t            in_data;
  logic                out_valid;
  logic                out_ready;
  d2q9_out_t           out_data;
  logic                cfg_we;
  logic [OMEGA_W-1:0]  cfg_data;
  int                  fail_count;
  int                  pending;
  int                  nodes_seen;
  int                  idle_cycles;
  int                  stall_hold;
  bit                  stall_long;
  int                  nodes_sent;

  d2q9_bgk_collision_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  d2q9_collision_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .nodes_seen(nodes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: stalls on a randomly chosen pattern, with one long hold-off on request.
  initial begin
    int mode;
    out_ready = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (stall_long) begin
        out_ready <= 1'b0;
        stall_hold++;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 1) != 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no transfer.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("d2q9_bgk_collision_top_tb: errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_pop();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      4: return 32'($urandom_range(0, 1 << 26));
      default: return 32'($urandom_range(1 << 24, 1 << 26));
    endcase
  endfunction

  function automatic d2q9_in_t rand_node();
    logic [NDIR-1:0][31:0] v;
    for (int i = 0; i < NDIR; i++) v[i] = rand_pop();
    return v;
  endfunction

  // Near-equilibrium node: density about 1.0 with small random flow.
  function automatic d2q9_in_t flow_node();
    logic [NDIR-1:0][31:0] v;
    for (int i = 0; i < NDIR; i++)
      v[i] = (i == 8) ? 32'd119304647 + $urandom_range(0, 1 << 22)
                      : 32'd14913080 + $urandom_range(0, 1 << 23);
    return v;
  endfunction

  function automatic d2q9_in_t fill_node(logic [31:0] val);
    logic [NDIR-1:0][31:0] v;
    for (int i = 0; i < NDIR; i++) v[i] = val;
    return v;
  endfunction

  // Offer one node and hold it until the transfer.
  task automatic send_node(d2q9_in_t n);
    in_valid <= 1'b1;
    in_data <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    nodes_sent++;
  endtask

  task automatic gap_cycles(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_and_set(logic [OMEGA_W-1:0] om);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= om;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int burst;
    int k;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && k < count; b++) begin
        case ($urandom_range(0, 3))
          0: send_node(rand_node());
          default: send_node(flow_node());
        endcase
        k++;
      end
      gap_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
    end
  endtask

  initial begin
    logic [NDIR-1:0][31:0] v;
    logic [OMEGA_W-1:0] omegas [5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    stall_long = 1'b0;
    stall_hold = 0;
    nodes_sent = 0;
    omegas = '{30'd0, 30'h3fff_ffff, 30'd536870912, 30'd201326592, 30'd400000000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero and negative density, saturating sums and flow.
    send_node(fill_node(32'h0));
    send_node(fill_node(32'h7fff_ffff));
    send_node(fill_node(32'h8000_0000));
    send_node(fill_node(32'hffff_ffff));
    send_node(fill_node(32'd29826162));
    send_node(flow_node());
    v = fill_node(32'd0);
    v[NDIR-1-1] = 32'h1000_0000;
    send_node(v);
    v[NDIR-1-1] = 32'h7fff_ffff;
    v[NDIR-1-3] = 32'h8000_0000;
    send_node(v);
    v = fill_node(32'd0);
    v[NDIR-1-5] = 32'h7fff_ffff;
    v[NDIR-1-0] = 32'd1;
    send_node(v);
    v = fill_node(32'd0);
    v[NDIR-1-7] = 32'h4000_0000;
    v[NDIR-1-2] = 32'd16;
    send_node(v);
    v = fill_node(32'haaaa_aaaa);
    send_node(v);
    send_node(fill_node(32'h5555_5555));
    for (int i = 0; i < 8; i++) send_node(rand_node());

    // Long receiver hold-off while nodes keep coming.
    stall_long = 1'b1;
    fork
      random_phase(80);
      begin
        while (stall_hold < 300) @(posedge clk);
        stall_long = 1'b0;
      end
    join

    foreach (omegas[j]) begin
      drain_and_set(omegas[j]);
      random_phase(150);
    end
    drain_and_set(RELAX_RST);
    random_phase(100);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("sent %0d nodes, checked %0d results over 6 relax-rate settings",
             nodes_sent, nodes_seen);
    if (fail_count == 0) begin
      $display("d2q9_bgk_collision_top_tb: clean");
    end else begin
      $display("d2q9_bgk_collision_top_tb: errors");
    end
    $finish;
  end
endmodule
